@@ rtl/apm_pkg.sv @@
// Shared types and constants for the automaton pattern matcher.
package apm_pkg;

  localparam int unsigned BYTE_WIDTH      = 8;
  localparam int unsigned PATTERN_CHARS   = 8;
  localparam int unsigned PATTERN_WIDTH   = BYTE_WIDTH * PATTERN_CHARS;
  localparam int unsigned LEN_WIDTH       = 4;
  localparam int unsigned SHIFT_SEL_WIDTH = $clog2(PATTERN_CHARS);
  localparam int unsigned POS_WIDTH       = 32;
  localparam int unsigned TOTAL_WIDTH     = 32;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam logic [PATTERN_WIDTH-1:0] PATTERN_RESET = 64'd1919508845;
  localparam logic [LEN_WIDTH-1:0]     LENGTH_RESET  = 4'd4;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1
  } cfg_reg_t;

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic step;
    logic clear;
    logic resync;
  } cell_ctrl_t;

  typedef struct packed {
    logic                   found;
    logic [POS_WIDTH-1:0]   shift;
    logic [TOTAL_WIDTH-1:0] total;
    logic                   finished;
  } result_t;

endpackage

@@ rtl/apm_cell.sv @@
// One cell of the matcher row: tracks whether a pattern prefix of length IDX+1 ends here.
module apm_cell import apm_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic [BYTE_WIDTH-1:0]    text_byte,
  input  logic [PATTERN_WIDTH-1:0] pattern_bytes,
  input  logic [LEN_WIDTH-1:0]     used_len,
  input  logic [LEN_WIDTH-1:0]     base_len,
  input  logic                     prev_hit,
  output logic                     hit_next,
  output logic                     hit
);

  localparam logic [LEN_WIDTH-1:0] POS = LEN_WIDTH'(IDX);

  logic [PATTERN_CHARS-1:0]   overlap;
  logic [LEN_WIDTH-1:0]       shift_sel;
  logic                       border;
  logic                       prev;

  // overlap[s]: the first IDX pattern characters equal those starting s places later.
  always_comb begin
    overlap = '1;
    for (int s = 0; s < PATTERN_CHARS; s++) begin
      for (int i = 0; i < PATTERN_CHARS; i++) begin
        if ((i < IDX) && (i + s < PATTERN_CHARS)) begin
          if (pattern_bytes[BYTE_WIDTH*i +: BYTE_WIDTH] !=
              pattern_bytes[BYTE_WIDTH*(i+s) +: BYTE_WIDTH]) begin
            overlap[s] = 1'b0;
          end
        end
      end
    end
  end

  // After a register write the row is rebuilt from the stored prefix length alone:
  // a prefix of length IDX counts if it is a border of the stored prefix.
  assign shift_sel = base_len - POS;
  assign border    = (POS <= base_len) && overlap[shift_sel[SHIFT_SEL_WIDTH-1:0]];

  always_comb begin
    if (IDX == 0) begin
      prev = 1'b1;
    end else if (ctrl.resync) begin
      prev = border;
    end else begin
      prev = prev_hit;
    end
  end

  assign hit_next = prev && (POS < used_len) &&
                    (pattern_bytes[BYTE_WIDTH*IDX +: BYTE_WIDTH] == text_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.step) begin
      hit <= ctrl.clear ? 1'b0 : hit_next;
    end
  end

endmodule

@@ rtl/automaton_pattern_matcher_top.sv @@
// Top level of the automaton pattern matcher: cell row, counters, config and output buffer.
//
// Streams text bytes, one item per clock while in_ready is high, against a configured
// pattern of up to MAX_PATTERN bytes and returns one result item per text byte. A row of
// MAX_PATTERN cells holds, for every prefix length, whether that prefix ends at the
// current character; each cell takes its left neighbour's flag on every accepted item,
// so the next matched length is known in the cycle an item is accepted, and overlapping
// matches are reported. The result of each item is registered in the output buffer. A
// two-entry output buffer lets the block keep taking items while one result
// waits downstream; input ready drops only when both entries are full. Register
// writes are taken in any cycle (cfg_ready is always high) and do not clear the
// match state: the row is rebuilt from the stored prefix length on the next item.
// An item with end_of_text set clears the prefix, position and match count after
// its result is formed.
module automaton_pattern_matcher_top import apm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [PATTERN_WIDTH-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [BYTE_WIDTH-1:0]      text_byte,
  input  logic                       end_of_text,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       match_found,
  output logic [POS_WIDTH-1:0]       match_shift,
  output logic [TOTAL_WIDTH-1:0]     match_total,
  output logic                       text_finished
);

  localparam logic [LEN_WIDTH-1:0]   MAX_LEN   = LEN_WIDTH'(MAX_PATTERN);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [PATTERN_WIDTH-1:0] pattern_bytes;
  logic [LEN_WIDTH-1:0]     pattern_length;
  logic [LEN_WIDTH-1:0]     matched_prefix;
  logic [POS_WIDTH-1:0]     char_position;
  logic [COUNT_WIDTH-1:0]   match_counter;
  logic                     resync;

  logic [LEN_WIDTH-1:0]     used_len;
  logic [LEN_WIDTH-1:0]     base_len;
  logic [LEN_WIDTH-1:0]     prefix_next;
  logic [MAX_PATTERN-1:0]   hit_next;
  logic [MAX_PATTERN-1:0]   hit;
  logic [MAX_PATTERN-1:0]   prev_vec;
  logic [COUNT_WIDTH-1:0]   counter_bumped;
  logic [TOTAL_WIDTH-1:0]   total_now;
  logic                     in_accept;
  logic                     out_pop;
  logic                     found;
  cell_ctrl_t               ctrl;
  result_t                  result_new;
  result_t                  out_reg;
  result_t                  skid_reg;
  logic                     skid_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign out_pop   = out_valid && out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= PATTERN_RESET;
      pattern_length <= LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      used_len = LEN_WIDTH'(1);
    end else if (pattern_length > MAX_LEN) begin
      used_len = MAX_LEN;
    end else begin
      used_len = pattern_length;
    end
    base_len = (matched_prefix > used_len) ? used_len : matched_prefix;
  end

  assign ctrl.step   = in_accept;
  assign ctrl.clear  = end_of_text;
  assign ctrl.resync = resync;

  always_comb begin
    prev_vec[0] = 1'b1;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      prev_vec[j] = hit[j-1];
    end
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    apm_cell #(.IDX(g)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .text_byte    (text_byte),
      .pattern_bytes(pattern_bytes),
      .used_len     (used_len),
      .base_len     (base_len),
      .prev_hit     (prev_vec[g]),
      .hit_next     (hit_next[g]),
      .hit          (hit[g])
    );
  end

  // The longest prefix that ends at this character wins.
  always_comb begin
    prefix_next = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (hit_next[j]) begin
        prefix_next = LEN_WIDTH'(j + 1);
      end
    end
  end

  assign found          = (prefix_next == used_len);
  assign counter_bumped = (found && (match_counter != COUNT_MAX)) ?
                          match_counter + COUNT_WIDTH'(1) : match_counter;

  if (COUNT_WIDTH > TOTAL_WIDTH) begin : g_total_sat
    assign total_now = (|counter_bumped[COUNT_WIDTH-1:TOTAL_WIDTH]) ? '1 :
                       counter_bumped[TOTAL_WIDTH-1:0];
  end else begin : g_total_ext
    assign total_now = TOTAL_WIDTH'(counter_bumped);
  end

  always_comb begin
    result_new.found    = found;
    result_new.shift    = found ?
                          (char_position - POS_WIDTH'(used_len) + POS_WIDTH'(1)) : '0;
    result_new.total    = total_now;
    result_new.finished = end_of_text;
  end

  // Match state.
  always_ff @(posedge clk) begin
    if (rst) begin
      matched_prefix <= '0;
      char_position  <= '0;
      match_counter  <= '0;
      resync         <= 1'b0;
    end else begin
      if (in_accept) begin
        resync <= 1'b0;
        if (end_of_text) begin
          matched_prefix <= '0;
          char_position  <= '0;
          match_counter  <= '0;
        end else begin
          matched_prefix <= prefix_next;
          char_position  <= char_position + POS_WIDTH'(1);
          match_counter  <= counter_bumped;
        end
      end
      // A write lands after any item of this cycle, so it wins.
      if (cfg_valid && cfg_ready) begin
        resync <= 1'b1;
      end
    end
  end

  // Two-entry output buffer: the skid entry only fills while the head is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_reg <= skid_reg;
      end
    end else if (in_accept) begin
      if (out_valid && !out_ready) begin
        skid_reg <= result_new;
      end else begin
        out_reg <= result_new;
      end
    end
  end

  assign match_found   = out_reg.found;
  assign match_shift   = out_reg.shift;
  assign match_total   = out_reg.total;
  assign text_finished = out_reg.finished;

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the head is empty");

  a_prefix_in_range: assert property (@(posedge clk) disable iff (rst)
    matched_prefix <= MAX_LEN)
    else $error("matched prefix exceeds the cell row");

  a_shift_zero_no_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !match_found) |-> (match_shift == '0))
    else $error("shift reported without a match");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && end_of_text) |=> ((char_position == '0) && (matched_prefix == '0)
                                    && (hit == '0)))
    else $error("end of text did not clear the match state");
`endif

endmodule

@@ bench/tb_automaton_pattern_matcher_top.sv @@
// Self-checking testbench for automaton_pattern_matcher_top: directed table, then random texts.
`timescale 1ns / 100ps

module tb_automaton_pattern_matcher_top;
  import apm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned END_CYCLES   = 4;

  // Index values that name no register; writes to them must leave everything alone.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_3 = 2'd3;

  localparam result_t NO_RESULT = '{1'b0, 32'd0, 32'd0, 1'b0};

  typedef enum logic {ROW_TEXT, ROW_WRITE} row_kind_e;
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_MOSTLY, RX_MASK, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    logic [PATTERN_WIDTH-1:0]   data;
    logic [BYTE_WIDTH-1:0]      ch;
    logic                       eot;
    bit                         typed;
    result_t                    want;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 30;

  // The reset pattern spells "mair" with length 4.
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, "m",    1'b0, 1'b1, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, "a",    1'b0, 1'b1, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, "i",    1'b0, 1'b1, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, "r",    1'b0, 1'b1,
      '{1'b1, 32'd0, 32'd1, 1'b0}},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b1, 1'b1,
      '{1'b0, 32'd0, 32'd1, 1'b1}},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'h00,  1'b0, 1'b1, NO_RESULT},
    // Length zero in the low nibble counts as one; the upper data bits are ignored.
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'hffff_ffff_ffff_fff0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, "m",    1'b0, 1'b1,
      '{1'b1, 32'd1, 32'd1, 1'b0}},
    '{ROW_WRITE, REG_SPARE_2,        64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_SPARE_3,        64'd0, 8'h00,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, "m",    1'b1, 1'b1,
      '{1'b1, 32'd2, 32'd2, 1'b1}},
    '{ROW_WRITE, REG_PATTERN_BYTES,  64'd0, 8'h00,  1'b0, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd2, 8'h00,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'h00,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'h00,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'h00,  1'b1, 1'b0, NO_RESULT},
    '{ROW_WRITE, REG_PATTERN_BYTES,  64'hffff_ffff_ffff_ffff, 8'h00, 1'b0, 1'b0, NO_RESULT},
    // Fifteen is clipped to the full eight characters.
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    // Shortening the pattern mid-text leaves a matched length above the new one.
    '{ROW_WRITE, REG_PATTERN_LENGTH, 64'd3, 8'h00,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'hff,  1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,  REG_PATTERN_BYTES,  64'd0, 8'h00,  1'b1, 1'b0, NO_RESULT}
  };

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_valid   = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
  logic [PATTERN_WIDTH-1:0]   cfg_data    = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [BYTE_WIDTH-1:0]      text_byte   = '0;
  logic                       end_of_text = 1'b0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic                       match_found;
  logic [POS_WIDTH-1:0]       match_shift;
  logic [TOTAL_WIDTH-1:0]     match_total;
  logic                       text_finished;

  automaton_pattern_matcher_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_found  (match_found),
    .match_shift  (match_shift),
    .match_total  (match_total),
    .text_finished(text_finished)
  );

  always #6 clk = ~clk;

  // Mirror of the matcher: registers and running text state.
  logic [PATTERN_WIDTH-1:0] pattern_q  = PATTERN_RESET;
  logic [LEN_WIDTH-1:0]     length_q   = LENGTH_RESET;
  logic [LEN_WIDTH-1:0]     prefix_q   = '0;
  logic [POS_WIDTH-1:0]     position_q = '0;
  logic [TOTAL_WIDTH-1:0]   hits_q     = '0;

  result_t     due_reports [$];
  int unsigned fails       = 0;
  int unsigned burst_left  = 0;
  int unsigned taken_items = 0;
  int unsigned hold_left   = 0;
  int unsigned win_left    = 0;
  int unsigned rx_cycle    = 0;
  rx_mode_e    rx_mode     = RX_OPEN;
  logic [7:0]  rx_mask     = 8'hff;

  function automatic logic [BYTE_WIDTH-1:0] pattern_char(input int unsigned i);
    return pattern_q[(i & 7) * BYTE_WIDTH +: BYTE_WIDTH];
  endfunction

  function automatic int unsigned length_in_use();
    int unsigned len;
    len = length_q;
    if (len == 0) len = 1;
    if (len > PATTERN_CHARS) len = PATTERN_CHARS;
    return len;
  endfunction

  // Longest pattern prefix that ends the matched prefix extended by ch.
  function automatic int unsigned longest_border(input int unsigned q, input int unsigned m,
                                                 input logic [BYTE_WIDTH-1:0] ch);
    int unsigned k;
    int unsigned j;
    bit          ok;
    k = (q + 1 < m) ? q + 1 : m;
    while (k > 0) begin
      ok = (pattern_char(k - 1) == ch);
      for (j = 0; ok && j + 1 < k; j++) begin
        if (pattern_char(j) != pattern_char(q + 1 - k + j)) ok = 1'b0;
      end
      if (ok) return k;
      k--;
    end
    return 0;
  endfunction

  function automatic result_t step_matcher(input logic [BYTE_WIDTH-1:0] ch, input logic eot);
    result_t     r;
    int unsigned m;
    int unsigned q;
    m = length_in_use();
    q = prefix_q;
    if (q > m) q = m;
    q = longest_border(q, m, ch);
    prefix_q = LEN_WIDTH'(q);
    r = NO_RESULT;
    r.finished = eot;
    if (q == m) begin
      r.found = 1'b1;
      r.shift = position_q - POS_WIDTH'(m) + 1'b1;
      if (hits_q != '1) hits_q++;
    end
    r.total = hits_q;
    position_q++;
    if (eot) begin
      prefix_q   = '0;
      position_q = '0;
      hits_q     = '0;
    end
    return r;
  endfunction

  function automatic logic [PATTERN_WIDTH-1:0] random_pattern();
    logic [PATTERN_WIDTH-1:0] p;
    logic [7:0]               sym [3];
    int unsigned              unit;
    int unsigned              i;
    for (i = 0; i < 3; i++) sym[i] = 8'($urandom);
    unit = $urandom_range(1, 3);
    p = {$urandom, $urandom};
    // Small alphabets and short periods give plenty of overlapping matches.
    case ($urandom_range(0, 3))
      0: p = {$urandom, $urandom};
      1: for (i = 0; i < 8; i++) p[i*8 +: 8] = sym[2'($urandom_range(0, 1))];
      2: for (i = 0; i < 8; i++) p[i*8 +: 8] = sym[2'(i % unit)];
      default: for (i = 0; i < 8; i++) p[i*8 +: 8] = sym[2'($urandom_range(0, 2))];
    endcase
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [PATTERN_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PATTERN_BYTES) pattern_q = data;
    else if (idx == REG_PATTERN_LENGTH) length_q = data[LEN_WIDTH-1:0];
  endtask

  task automatic push_text(input logic [BYTE_WIDTH-1:0] ch, input logic eot,
                           input bit typed, input result_t want);
    int unsigned gap;
    result_t     predicted;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    text_byte   <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_matcher(ch, eot);
    due_reports.push_back(typed ? want : predicted);
  endtask

  // Stop offering items and wait until every result item has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_report();
    result_t want;
    if (due_reports.size() == 0) begin
      $error("result item arrived with nothing due");
      fails++;
    end else begin
      want = due_reports.pop_front();
      if (match_found !== want.found) begin
        $error("match_found: expected %0d, got %0d", want.found, match_found);
        fails++;
      end
      if (match_shift !== want.shift) begin
        $error("match_shift: expected %0d, got %0d", want.shift, match_shift);
        fails++;
      end
      if (match_total !== want.total) begin
        $error("match_total: expected %0d, got %0d", want.total, match_total);
        fails++;
      end
      if (text_finished !== want.finished) begin
        $error("text_finished: expected %0d, got %0d", want.finished, text_finished);
        fails++;
      end
    end
  endtask

  // Result side: check accepted items, then choose the next ready level.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_report();
    if (!rst && in_valid && in_ready) begin
      taken_items++;
      // A long hold-off while items keep coming fills the output buffer.
      if (taken_items == 400 || taken_items == 1300) hold_left = HOLD_CYCLES;
    end
    if (win_left == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 4));
      rx_mask  = 8'($urandom);
      win_left = $urandom_range(16, 64);
    end
    win_left--;
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ready <= ($urandom_range(0, 99) < 85);
        RX_MASK:   out_ready <= rx_mask[3'(rx_cycle % 8)];
        default:   out_ready <= ($urandom_range(0, 99) < 20);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[automaton_pattern_matcher_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                row;
    logic [BYTE_WIDTH-1:0]    text_q [$];
    logic [PATTERN_WIDTH-1:0] len_data;
    int unsigned              random_sent;
    int unsigned              target;
    int unsigned              m;
    int unsigned              r;
    int unsigned              cut;
    int unsigned              t;
    int unsigned              n_texts;
    int unsigned              i;
    bit                       end_it;
    bit                       wr_pat;
    bit                       wr_len;
    bit                       spare;
    bit                       len_first;
    random_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.data);
      end else begin
        push_text(row.ch, row.eot, row.typed, row.want);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      drain_results();
      wr_pat    = ($urandom_range(0, 5) != 0);
      wr_len    = ($urandom_range(0, 5) != 0);
      spare     = ($urandom_range(0, 7) == 0);
      len_first = 1'($urandom_range(0, 1));
      len_data  = {$urandom, $urandom};
      len_data[LEN_WIDTH-1:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                            : 4'($urandom_range(1, 8));
      if (spare) write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
      if (wr_len && len_first) write_reg(REG_PATTERN_LENGTH, len_data);
      if (wr_pat) write_reg(REG_PATTERN_BYTES, random_pattern());
      if (wr_len && !len_first) write_reg(REG_PATTERN_LENGTH, len_data);

      n_texts = $urandom_range(1, 4);
      for (t = 0; t < n_texts; t++) begin
        // The last text of a phase is sometimes left open across the next register change.
        end_it = (t + 1 < n_texts) || ($urandom_range(0, 3) != 0);
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        m = length_in_use();
        text_q.delete();
        while (text_q.size() < target) begin
          r = $urandom_range(0, 9);
          if (r < 2) begin
            text_q.push_back(8'($urandom));
          end else if (r < 4) begin
            text_q.push_back(pattern_char($urandom_range(0, m - 1)));
          end else begin
            cut = (r < 7) ? m : $urandom_range(1, m);
            for (i = 0; i < cut; i++) text_q.push_back(pattern_char(i));
          end
        end
        for (i = 0; i < text_q.size(); i++) begin
          push_text(text_q[i], end_it && (i == text_q.size() - 1), 1'b0, NO_RESULT);
          random_sent++;
        end
      end
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (fails == 0)
      $display("[automaton_pattern_matcher_top] OK");
    else
      $display("[automaton_pattern_matcher_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/apm_pkg.sv
rtl/apm_cell.sv
rtl/automaton_pattern_matcher_top.sv
bench/tb_automaton_pattern_matcher_top.sv
